FILE: rtl/core/gtg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtg_pkg
// shared types, constants and the arctangent table of the go-to-goal controller
// ----------------------------------------------------------------------------
package gtg_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_ENTRIES  = 24;
  localparam int NUM_CELLS     = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

  // datapath widths
  localparam int XY_W  = 36;   // cordic x/y, 16 fraction bits on top of Q10
  localparam int Z_W   = 28;   // angle accumulator, Q24 radians
  localparam int IDX_W = 5;    // stage index into the arctangent table

  localparam logic signed [Z_W-1:0] HALF_PI_Q24  = 28'sd26353589;
  localparam logic signed [17:0]    PI_Q13       = 18'sd25736;
  localparam logic signed [17:0]    TWO_PI_Q13   = 18'sd51472;
  localparam logic [15:0]           INV_GAIN_Q16 = 16'd39797;

  // configuration register indexes
  localparam logic [1:0] CFG_LINEAR_GAIN     = 2'd0;
  localparam logic [1:0] CFG_ANGULAR_GAIN    = 2'd1;
  localparam logic [1:0] CFG_CATCH_TOLERANCE = 2'd2;

  localparam logic [23:0] ATAN_Q24 [ATAN_ENTRIES] = '{
    24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331, 24'd1047214, 24'd524117,
    24'd262123, 24'd131069, 24'd65536, 24'd32768, 24'd16384, 24'd8192,
    24'd4096, 24'd2048, 24'd1024, 24'd512, 24'd256, 24'd128,
    24'd64, 24'd32, 24'd16, 24'd8, 24'd4, 24'd2
  };

  // item travelling down the cordic chain
  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic signed [15:0]     heading;
    logic                   active;   // target valid
    logic                   zero;     // robot sits exactly on the target
  } gtg_item_t;

  // finished command
  typedef struct packed {
    logic        goal_reached;
    logic signed [15:0] turn_rate;
    logic [15:0] linear_speed;
  } gtg_result_t;

endpackage

FILE: rtl/core/gtg_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtg_cordic_cell
// one vectoring micro-rotation with its own pipeline register and handshake
// ----------------------------------------------------------------------------
module gtg_cordic_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [gtg_pkg::IDX_W-1:0] stage_idx,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  gtg_pkg::gtg_item_t        in_item,
  output logic                      out_valid,
  input  logic                      out_ready,
  output gtg_pkg::gtg_item_t        out_item
);
  import gtg_pkg::*;

  logic                   valid_q;
  gtg_item_t              item_q;
  gtg_item_t              item_next;
  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;
  logic signed [Z_W-1:0]  atan_step;

  assign in_ready  = !valid_q || out_ready;
  assign out_valid = valid_q;
  assign out_item  = item_q;

  always_comb begin
    xs        = in_item.x >>> stage_idx;
    ys        = in_item.y >>> stage_idx;
    atan_step = Z_W'(ATAN_Q24[stage_idx]);
    item_next = in_item;
    if (!in_item.y[XY_W-1]) begin
      item_next.x = in_item.x + ys;
      item_next.y = in_item.y - xs;
      item_next.z = in_item.z + atan_step;
    end else begin
      item_next.x = in_item.x - ys;
      item_next.y = in_item.y + xs;
      item_next.z = in_item.z - atan_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (in_ready) begin
      valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_q <= item_next;
    end
  end

endmodule

FILE: rtl/core/gtg_post.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtg_post
// gain scaling, heading error wrap, rounding and saturation after the cordic
// ----------------------------------------------------------------------------
module gtg_post (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [11:0]           linear_gain,
  input  logic [11:0]           angular_gain,
  input  logic [15:0]           catch_tolerance,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  gtg_pkg::gtg_item_t    in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output gtg_pkg::gtg_result_t  out_res
);
  import gtg_pkg::*;

  logic v1, v2, v3, v4;
  logic r1, r2, r3, r4;

  // stage 1: partial products of the gain correction, heading error
  logic               act1, dz1;
  logic [32:0]        pl1, ph1;
  logic signed [17:0] err1;
  // stage 2: distance, catch compare
  logic               act2, reached2;
  logic [18:0]        dist2;
  logic signed [17:0] err2;
  // stage 3: gain products
  logic               act3, reached3;
  logic [30:0]        lin_p3;
  logic signed [30:0] turn_p3;
  // stage 4: output register
  gtg_result_t        res4;

  logic [33:0]        ux;
  logic signed [16:0] bear;
  logic signed [Z_W-1:0] zr;
  logic signed [17:0] err_raw;
  logic signed [17:0] err_wrap;
  logic [50:0]        dsum;
  logic [31:0]        lin_r;
  logic signed [31:0] turn_r;
  logic signed [20:0] turn_s;
  gtg_result_t        res_next;

  assign r4 = !v4 || out_ready;
  assign r3 = !v3 || r4;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign in_ready  = r1;
  assign out_valid = v4;
  assign out_res   = res4;

  always_comb begin
    ux   = in_item.x[33:0];
    zr   = in_item.z + Z_W'(1024);
    bear = in_item.zero ? 17'sd0 : zr[27:11];
    err_raw = 18'(bear) - 18'(in_item.heading);
    if (err_raw > PI_Q13) begin
      err_wrap = err_raw - TWO_PI_Q13;
    end else if (err_raw < -PI_Q13) begin
      err_wrap = err_raw + TWO_PI_Q13;
    end else begin
      err_wrap = err_raw;
    end
  end

  always_comb begin
    dsum = {1'b0, ph1, 17'b0} + {18'b0, pl1} + 51'h0_8000_0000;
  end

  always_comb begin
    lin_r  = {1'b0, lin_p3} + 32'd128;
    turn_r = 32'(turn_p3) + 32'sd1024;
    turn_s = turn_r[31:11];
    res_next.linear_speed = (lin_r[31:24] != 8'd0) ? 16'hFFFF : lin_r[23:8];
    if (turn_s > 21'sd32767) begin
      res_next.turn_rate = 16'sh7FFF;
    end else if (turn_s < -21'sd32768) begin
      res_next.turn_rate = -16'sh8000;
    end else begin
      res_next.turn_rate = turn_s[15:0];
    end
    res_next.goal_reached = reached3;
    if (!act3) begin
      res_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && in_valid) begin
      act1 <= in_item.active;
      // x never goes negative after the pre-rotation; guarded anyway
      dz1  <= in_item.zero || in_item.x[XY_W-1];
      pl1  <= 33'(ux[16:0]) * 33'(INV_GAIN_Q16);
      ph1  <= 33'(ux[33:17]) * 33'(INV_GAIN_Q16);
      err1 <= err_wrap;
    end
    if (r2 && v1) begin
      act2     <= act1;
      dist2    <= dz1 ? 19'd0 : dsum[50:32];
      reached2 <= dz1 || (dsum[50:32] <= {3'b0, catch_tolerance});
      err2     <= err1;
    end
    if (r3 && v2) begin
      act3     <= act2;
      reached3 <= reached2;
      lin_p3   <= 31'(linear_gain) * 31'(dist2);
      turn_p3  <= 31'($signed({1'b0, angular_gain})) * 31'(err2);
    end
    if (r4 && v3) begin
      res4 <= res_next;
    end
  end

endmodule

FILE: rtl/core/go_to_goal_p_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// go_to_goal_p_controller
// proportional go-to-goal controller with a pipelined cordic for range and bearing
// ----------------------------------------------------------------------------
// Takes one pose/target transfer per clock while m_tready does not stall it,
// and returns one speed command per input, in order. The pipeline holds one
// entry register for the offset and quadrant pre-rotation, one cell per
// cordic micro-rotation, then four stages for the magnitude correction, gain
// products and saturation, the last of which is the output register. Each
// stage has its own valid bit, so bubbles close up and a new transfer is
// taken while a finished result still waits on m_tready. Gains and the catch
// tolerance come from the write port and should only change while the block
// is empty. An invalid target gives an all-zero command.
module go_to_goal_p_controller (
  input  logic        clk,
  input  logic        rst,
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // pose and target
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // own_x, own_y, own_heading, goal_x, goal_y
  input  logic        s_tuser,   // goal_valid
  // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // linear_speed, turn_rate, goal_reached, zero pad
);
  import gtg_pkg::*;

  logic [11:0] linear_gain;
  logic [11:0] angular_gain;
  logic [15:0] catch_tolerance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      linear_gain     <= 12'd256;
      angular_gain    <= 12'd1024;
      catch_tolerance <= 16'd512;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LINEAR_GAIN:     linear_gain     <= cfg_data[11:0];
        CFG_ANGULAR_GAIN:    angular_gain    <= cfg_data[11:0];
        CFG_CATCH_TOLERANCE: catch_tolerance <= cfg_data;
        default: ;
      endcase
    end
  end

  // entry stage: offset to the target and turn into the right half plane
  logic signed [15:0]     own_x, own_y, own_heading, goal_x, goal_y;
  logic signed [16:0]     dx, dy;
  logic signed [XY_W-1:0] x0, y0;
  gtg_item_t              entry_next;
  gtg_item_t              entry_q;
  logic                   entry_valid;

  logic                   cell_valid [NUM_CELLS+1];
  logic                   cell_ready [NUM_CELLS+1];
  gtg_item_t              cell_item  [NUM_CELLS+1];

  assign own_x       = s_tdata[15:0];
  assign own_y       = s_tdata[31:16];
  assign own_heading = s_tdata[47:32];
  assign goal_x      = s_tdata[63:48];
  assign goal_y      = s_tdata[79:64];

  always_comb begin
    dx = 17'(goal_x) - 17'(own_x);
    dy = 17'(goal_y) - 17'(own_y);
    x0 = {XY_W'(dx)} <<< 16;
    y0 = {XY_W'(dy)} <<< 16;
    entry_next.heading = own_heading;
    entry_next.active  = s_tuser;
    entry_next.zero    = (dx == 17'sd0) && (dy == 17'sd0);
    entry_next.x       = x0;
    entry_next.y       = y0;
    entry_next.z       = '0;
    if (dx[16]) begin
      if (!dy[16]) begin
        entry_next.x = y0;
        entry_next.y = -x0;
        entry_next.z = HALF_PI_Q24;
      end else begin
        entry_next.x = -y0;
        entry_next.y = x0;
        entry_next.z = -HALF_PI_Q24;
      end
    end
  end

  assign s_tready = !entry_valid || cell_ready[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= 1'b0;
    end else if (s_tready) begin
      entry_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      entry_q <= entry_next;
    end
  end

  assign cell_valid[0] = entry_valid;
  assign cell_item[0]  = entry_q;

  // row of micro-rotation cells, each hands its item to the next
  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    gtg_cordic_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .stage_idx (IDX_W'(g)),
      .in_valid  (cell_valid[g]),
      .in_ready  (cell_ready[g]),
      .in_item   (cell_item[g]),
      .out_valid (cell_valid[g+1]),
      .out_ready (cell_ready[g+1]),
      .out_item  (cell_item[g+1])
    );
  end

  gtg_result_t res;

  gtg_post u_post (
    .clk             (clk),
    .rst             (rst),
    .linear_gain     (linear_gain),
    .angular_gain    (angular_gain),
    .catch_tolerance (catch_tolerance),
    .in_valid        (cell_valid[NUM_CELLS]),
    .in_ready        (cell_ready[NUM_CELLS]),
    .in_item         (cell_item[NUM_CELLS]),
    .out_valid       (m_tvalid),
    .out_ready       (m_tready),
    .out_res         (res)
  );

  assign m_tdata = {7'b0, res.goal_reached, res.turn_rate, res.linear_speed};

  // an empty entry register always takes a transfer
  a_entry_free: assert property (@(posedge clk) disable iff (rst)
    !entry_valid |-> s_tready)
    else $error("entry register empty but input stalled");

  // a stalled entry item is neither lost nor changed
  a_entry_hold: assert property (@(posedge clk) disable iff (rst)
    entry_valid && !cell_ready[0] |=> entry_valid && $stable(entry_q))
    else $error("entry item dropped or changed while stalled");

  // the last cell keeps its item until the post stage takes it
  a_chain_hold: assert property (@(posedge clk) disable iff (rst)
    cell_valid[NUM_CELLS] && !cell_ready[NUM_CELLS] |=> cell_valid[NUM_CELLS])
    else $error("cordic output lost while post stage stalled");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule

FILE: tb/tb_go_to_goal_p_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_go_to_goal_p_controller
// self-checking bench for the go-to-goal proportional controller
// ----------------------------------------------------------------------------
// Drives pose/target transfers through the stream input and compares each
// speed command with a bit-exact fixed-point prediction of range, bearing,
// wrapped heading error, gain products and saturation. A directed set covers
// invalid targets, zero offsets, quadrant pre-rotations, full-scale offsets
// and headings beyond pi; random phases follow, each with its own gains and
// tolerance and a chosen mix of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_go_to_goal_p_controller;
  import gtg_pkg::*;

  localparam int LATENCY = NUM_CELLS + 5;
  localparam int LIMIT   = 200000;

  // one pose/target transfer
  typedef struct {
    logic signed [15:0] own_x;
    logic signed [15:0] own_y;
    logic signed [15:0] heading;
    logic signed [15:0] goal_x;
    logic signed [15:0] goal_y;
    logic               valid;
  } pose_t;

  // one speed command
  typedef struct {
    logic [15:0]        linear_speed;
    logic signed [15:0] turn_rate;
    logic               goal_reached;
  } cmd_t;

  // predicts commands from accepted poses and checks them in order
  class cmd_scoreboard;
    bit [11:0] lin_gain  = 12'd256;
    bit [11:0] ang_gain  = 12'd1024;
    bit [15:0] tolerance = 16'd512;
    cmd_t      pending_cmds[$];
    int        failures;

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        CFG_LINEAR_GAIN:     lin_gain  = val[11:0];
        CFG_ANGULAR_GAIN:    ang_gain  = val[11:0];
        CFG_CATCH_TOLERANCE: tolerance = val;
        default: ;
      endcase
    endfunction

    function cmd_t predict_command(pose_t p);
      cmd_t   c;
      longint dx, dy, x, y, z, t, xs, ys, distance, bear, err, lin, turn;
      int     i;
      c.linear_speed = '0;
      c.turn_rate    = '0;
      c.goal_reached = 1'b0;
      if (!p.valid) return c;
      dx = longint'(p.goal_x) - longint'(p.own_x);
      dy = longint'(p.goal_y) - longint'(p.own_y);
      if (dx == 0 && dy == 0) begin
        distance = 0;
        bear = 0;
      end else begin
        x = dx * 65536;
        y = dy * 65536;
        z = 0;
        // left half plane: turn by a quarter so the micro-rotations converge
        if (x < 0) begin
          t = x;
          if (y >= 0) begin
            x = y;
            y = -t;
            z = longint'(HALF_PI_Q24);
          end else begin
            x = -y;
            y = t;
            z = -longint'(HALF_PI_Q24);
          end
        end
        for (i = 0; i < NUM_CELLS; i++) begin
          xs = x >>> i;
          ys = y >>> i;
          if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + longint'(ATAN_Q24[i]);
          end else begin
            x = x - ys;
            y = y + xs;
            z = z - longint'(ATAN_Q24[i]);
          end
        end
        distance = (x * longint'(INV_GAIN_Q16) + (longint'(1) << 31)) >>> 32;
        if (distance < 0) distance = 0;
        bear = (z + 1024) >>> 11;
      end
      // single wrap only, so headings past pi can leave the error outside
      err = bear - longint'(p.heading);
      if (err > longint'(PI_Q13)) err = err - longint'(TWO_PI_Q13);
      else if (err < -longint'(PI_Q13)) err = err + longint'(TWO_PI_Q13);
      lin = (longint'(lin_gain) * distance + 128) >>> 8;
      if (lin > 65535) lin = 65535;
      turn = (longint'(ang_gain) * err + 1024) >>> 11;
      if (turn > 32767) turn = 32767;
      else if (turn < -32768) turn = -32768;
      c.linear_speed = lin[15:0];
      c.turn_rate    = turn[15:0];
      c.goal_reached = (distance <= longint'(tolerance));
      return c;
    endfunction

    function void note_pose(pose_t p);
      pending_cmds.push_back(predict_command(p));
    endfunction

    function void check_command(cmd_t got);
      cmd_t want;
      if (pending_cmds.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected command: speed %0d turn %0d reached %0d",
                   got.linear_speed, got.turn_rate, got.goal_reached);
        return;
      end
      want = pending_cmds.pop_front();
      if (got.linear_speed !== want.linear_speed || got.turn_rate !== want.turn_rate ||
          got.goal_reached !== want.goal_reached) begin
        failures++;
        if (failures <= 10)
          $display("command mismatch: expected speed %0d turn %0d reached %0d, got %0d %0d %0d",
                   want.linear_speed, want.turn_rate, want.goal_reached,
                   got.linear_speed, got.turn_rate, got.goal_reached);
      end
    endfunction

    function int pending_count();
      return pending_cmds.size();
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data  = '0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata   = '0;   // own_x, own_y, own_heading, goal_x, goal_y
  logic        s_tuser   = 1'b0; // goal_valid
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [39:0] m_tdata;          // linear_speed, turn_rate, goal_reached, zero pad

  cmd_scoreboard sb = new();
  int send_idle_pct = 0;   // chance in a hundred that the sender idles a cycle
  int stall_pct     = 0;   // chance in a hundred that the receiver stalls a cycle
  int cycle_count   = 0;

  go_to_goal_p_controller u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // watchdog against a hung handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("go_to_goal_p_controller verification failed");
      $finish;
    end
  end

  // receiver back-pressure, one decision per cycle
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // transfer monitor: values seen here are the ones the edge sampled
  always @(posedge clk) begin : monitor_b
    pose_t seen;
    cmd_t  got;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        seen.own_x   = s_tdata[15:0];
        seen.own_y   = s_tdata[31:16];
        seen.heading = s_tdata[47:32];
        seen.goal_x  = s_tdata[63:48];
        seen.goal_y  = s_tdata[79:64];
        seen.valid   = s_tuser;
        sb.note_pose(seen);
      end
      if (m_tvalid && m_tready) begin
        got.linear_speed = m_tdata[15:0];
        got.turn_rate    = m_tdata[31:16];
        got.goal_reached = m_tdata[32];
        sb.check_command(got);
      end
    end
  end

  function automatic pose_t make_pose(int ox, int oy, int hd, int gx, int gy, bit v);
    pose_t p;
    p.own_x   = ox[15:0];
    p.own_y   = oy[15:0];
    p.heading = hd[15:0];
    p.goal_x  = gx[15:0];
    p.goal_y  = gy[15:0];
    p.valid   = v;
    return p;
  endfunction

  // offer one pose, with random idle cycles ahead of it
  task automatic send_pose(input pose_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {p.goal_y, p.goal_x, p.heading, p.own_y, p.own_x};
    s_tuser  <= p.valid;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // wait until every predicted command has come back, then let the pipe settle
  task automatic drain();
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  // write all three registers on consecutive cycles while the block is empty
  task automatic write_regs(input bit [11:0] lg, input bit [11:0] ag, input bit [15:0] tol);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LINEAR_GAIN;
    cfg_data  <= {4'd0, lg};
    sb.set_reg(CFG_LINEAR_GAIN, {4'd0, lg});
    @(posedge clk);
    cfg_index <= CFG_ANGULAR_GAIN;
    cfg_data  <= {4'd0, ag};
    sb.set_reg(CFG_ANGULAR_GAIN, {4'd0, ag});
    @(posedge clk);
    cfg_index <= CFG_CATCH_TOLERANCE;
    cfg_data  <= tol;
    sb.set_reg(CFG_CATCH_TOLERANCE, tol);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // one random phase: new settings, new idling mix, then a burst of poses
  task automatic run_phase(input int n, input int idle, input int stall,
                           input bit [11:0] lg, input bit [11:0] ag, input bit [15:0] tol);
    pose_t p;
    int    kind, off, hd;
    drain();
    write_regs(lg, ag, tol);
    send_idle_pct = idle;
    stall_pct     = stall;
    repeat (n) begin
      kind      = $urandom_range(99);
      p.own_x   = 16'($urandom);
      p.own_y   = 16'($urandom);
      p.goal_x  = 16'($urandom);
      p.goal_y  = 16'($urandom);
      p.valid   = (kind >= 8);
      if (kind >= 8 && kind < 16) begin
        // robot sitting on the target
        p.goal_x = p.own_x;
        p.goal_y = p.own_y;
      end else if (kind >= 16 && kind < 55) begin
        // short offsets, around the catch tolerance
        off      = int'($urandom_range(4096)) - 2048;
        p.goal_x = p.own_x + off[15:0];
        off      = int'($urandom_range(4096)) - 2048;
        p.goal_y = p.own_y + off[15:0];
      end
      if ($urandom_range(99) < 80) begin
        hd        = int'($urandom_range(51472)) - 25736;
        p.heading = hd[15:0];
      end else begin
        p.heading = 16'($urandom);
      end
      send_pose(p);
    end
    s_tvalid <= 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part at the reset settings, no idling
    send_pose(make_pose(100, 200, 300, 400, 500, 1'b0));       // invalid target
    send_pose(make_pose(-1, -1, -1, -1, -1, 1'b0));
    send_pose(make_pose(1000, -2000, 0, 1000, -2000, 1'b1));   // zero offset
    send_pose(make_pose(0, 0, 25736, 0, 0, 1'b1));
    send_pose(make_pose(0, 0, -25736, 0, 0, 1'b1));
    send_pose(make_pose(0, 0, -32768, 0, 0, 1'b1));            // heading past pi
    send_pose(make_pose(0, 0, 32767, 0, 0, 1'b1));
    send_pose(make_pose(-32768, 0, 0, 32767, 0, 1'b1));        // widest dx
    send_pose(make_pose(32767, 0, 0, -32768, 0, 1'b1));        // left half, dy zero
    send_pose(make_pose(32767, 32767, 0, -32768, -32768, 1'b1));
    send_pose(make_pose(-32768, 32767, 0, 32767, -32768, 1'b1));
    send_pose(make_pose(0, 0, 0, 0, 1024, 1'b1));              // on the y axis
    send_pose(make_pose(0, 0, 0, 0, -1024, 1'b1));
    send_pose(make_pose(0, 0, 0, -1024, 1024, 1'b1));          // left half, dy positive
    send_pose(make_pose(0, 0, 0, 511, 0, 1'b1));               // around the tolerance
    send_pose(make_pose(0, 0, 0, 512, 0, 1'b1));
    send_pose(make_pose(0, 0, 0, 513, 0, 1'b1));
    send_pose(make_pose(0, 0, -25736, -4096, 0, 1'b1));        // error wraps down
    send_pose(make_pose(0, 0, 25736, -4096, -1, 1'b1));        // error wraps up
    send_pose(make_pose(0, 0, 0, 1, 0, 1'b1));                 // smallest offsets
    send_pose(make_pose(0, 0, 0, -1, -1, 1'b1));
    s_tvalid <= 1'b0;

    run_phase(90, 0, 0, 12'd4095, 12'd4095, 16'd65535);
    run_phase(90, 80, 0, 12'd0, 12'd0, 16'd0);
    run_phase(90, 0, 80, 12'd256, 12'd1024, 16'd512);
    run_phase(90, 30, 30, 12'($urandom), 12'($urandom), 16'($urandom_range(4096)));
    run_phase(90, 0, 0, 12'($urandom), 12'($urandom), 16'($urandom));

    drain();
    if (sb.failures == 0 && sb.pending_count() == 0) begin
      $display("go_to_goal_p_controller verification clean");
    end else begin
      $display("go_to_goal_p_controller verification failed");
    end
    $finish;
  end

endmodule
